// ===== rtl/core/lfsa_pkg.sv =====
// lfsa_pkg: shared types and constants for the lowest free slot allocator
// used by lfsa_ctrl, lfsa_dp and lowest_free_slot_allocator_unit; no dependencies
`default_nettype none
package lfsa_pkg;

	// table geometry: the live map is kept as words of WORD_BITS flags
	localparam int SLOTS     = 1024;
	localparam int WORD_BITS = 32;
	localparam int WORDS     = SLOTS / WORD_BITS;
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int WIDX_W    = $clog2(WORDS);
	localparam int SLOT_W    = 10;
	localparam int CNT_W     = 11;
	localparam int DATA_W    = 32;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_QUERY  = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NOT_LIVE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_LOOKUP,
		S_EVAL
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load_in;
		logic lookup;
		logic eval;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/core/lowest_free_slot_allocator_unit.sv =====
// lowest_free_slot_allocator_unit: top level, stream packing around lfsa_ctrl and lfsa_dp
// depends on lfsa_pkg, lfsa_ctrl, lfsa_dp and lfsa_ram
//
// channel | dir | tdata            | tuser
// s_*     | in  | 80 bit request   | 2 bit operation
// m_*     | out | 88 bit result    | 2 bit status
//
// each transaction runs accept, one registered read of the live map
// word and the data ram, then evaluate, write back and load the output register
// the live map is 32 words of 32 flags with a full flag per word, so the lowest
// free slot is one word pick before the read and one bit pick after it
// reset clears the live count and the per word valid and full flags at once
// a waiting result holds the next evaluate step, and s_tready stays low meanwhile
`default_nettype none
module lowest_free_slot_allocator_unit
	import lfsa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [79:0] s_tdata,  // slot_index, position, taxon, zero pad
	input  wire logic [1:0]  s_tuser,  // operation
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [87:0]      m_tdata,  // assigned_slot, slot_live, stored_position,
	                                   // stored_taxon, live_count, zero pad
	output logic [1:0]       m_tuser   // status
);

	cmd_t              cmd;
	sts_t              sts;
	logic [SLOT_W-1:0] assigned_slot;
	logic              slot_live;
	logic [DATA_W-1:0] stored_position;
	logic [DATA_W-1:0] stored_taxon;
	logic [CNT_W-1:0]  live_count;

	lfsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	lfsa_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.operation       (s_tuser),
		.slot_index      (s_tdata[9:0]),
		.position        (s_tdata[41:10]),
		.taxon           (s_tdata[73:42]),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.status          (m_tuser),
		.assigned_slot   (assigned_slot),
		.slot_live       (slot_live),
		.stored_position (stored_position),
		.stored_taxon    (stored_taxon),
		.live_count      (live_count)
	);

	assign m_tdata = {2'b00, live_count, stored_taxon, stored_position, slot_live,
		assigned_slot};

endmodule
`default_nettype wire

// ===== rtl/core/lfsa_ram.sv =====
// lfsa_ram: generic single write port ram with registered read
// no dependencies
`default_nettype none
module lfsa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== rtl/core/lfsa_ctrl.sv =====
// lfsa_ctrl: sequencing of accept, lookup and evaluate for each transaction
// depends on lfsa_pkg
`default_nettype none
module lfsa_ctrl
	import lfsa_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	output cmd_t      cmd,
	input  wire sts_t sts
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd.load_in = 1'b0;
		cmd.lookup  = 1'b0;
		cmd.eval    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				cmd.lookup = 1'b1;
				state_d    = S_EVAL;
			end
			S_EVAL: begin
				// hold the read data until the output register can take the result
				if (sts.out_free) begin
					cmd.eval = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/core/lfsa_dp.sv =====
// lfsa_dp: input register, live map and data rams, slot search, output register
// depends on lfsa_pkg and lfsa_ram
`default_nettype none
module lfsa_dp
	import lfsa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	input  wire logic [1:0]        operation,
	input  wire logic [SLOT_W-1:0] slot_index,
	input  wire logic [DATA_W-1:0] position,
	input  wire logic [DATA_W-1:0] taxon,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [1:0]             status,
	output logic [SLOT_W-1:0]      assigned_slot,
	output logic                   slot_live,
	output logic [DATA_W-1:0]      stored_position,
	output logic [DATA_W-1:0]      stored_taxon,
	output logic [CNT_W-1:0]       live_count
);

	// accepted transaction
	logic [1:0]        op_q;
	logic [SLOT_W-1:0] slot_q;
	logic [DATA_W-1:0] pos_q;
	logic [DATA_W-1:0] tax_q;

	// table control state
	logic [CNT_W-1:0]  count_q;
	logic [WORDS-1:0]  wvalid_q;
	logic [WORDS-1:0]  word_full_q;
	logic [WIDX_W-1:0] word_q;

	// output register
	logic              m_tvalid_q;
	logic [1:0]        status_q;
	logic [SLOT_W-1:0] slot_out_q;
	logic              live_out_q;
	logic [DATA_W-1:0] pos_out_q;
	logic [DATA_W-1:0] tax_out_q;
	logic [CNT_W-1:0]  count_out_q;

	logic                   is_insert;
	logic                   is_remove;
	logic                   tbl_full;
	logic [WIDX_W-1:0]      free_word;
	logic [WIDX_W-1:0]      word_d;
	logic [WORD_BITS-1:0]   lm_rdata;
	logic [WORD_BITS-1:0]   live_word;
	logic [BIT_W-1:0]       free_bit;
	logic [BIT_W-1:0]       bit_sel;
	logic [WORD_BITS-1:0]   bit_mask;
	logic                   cur_live;
	logic [WORD_BITS-1:0]   new_word;
	logic                   lm_we;
	logic                   dr_we;
	logic [2*DATA_W-1:0]    dr_rdata;
	logic [CNT_W-1:0]       count_d;
	logic [1:0]             res_status;
	logic [SLOT_W-1:0]      res_slot;
	logic                   res_live;
	logic [DATA_W-1:0]      res_pos;
	logic [DATA_W-1:0]      res_tax;

	assign is_insert = (op_q == OP_INSERT);
	assign is_remove = (op_q == OP_REMOVE);
	assign tbl_full  = (count_q == CNT_W'(SLOTS));

	// lowest word that still has a free slot
	always_comb begin
		free_word = '0;
		for (int i = WORDS - 1; i >= 0; i--) begin
			if (!word_full_q[i]) begin
				free_word = WIDX_W'(i);
			end
		end
	end

	assign word_d = is_insert ? free_word : slot_q[SLOT_W-1 -: WIDX_W];

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q   <= operation;
			slot_q <= slot_index;
			pos_q  <= position;
			tax_q  <= taxon;
		end
		if (cmd.lookup) begin
			word_q <= word_d;
		end
	end

	lfsa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORDS)
	) u_live_ram (
		.clk   (clk),
		.we    (lm_we),
		.waddr (word_q),
		.wdata (new_word),
		.re    (cmd.lookup),
		.raddr (word_d),
		.rdata (lm_rdata)
	);

	lfsa_ram #(
		.WIDTH (2 * DATA_W),
		.DEPTH (SLOTS)
	) u_data_ram (
		.clk   (clk),
		.we    (dr_we),
		.waddr ({word_q, free_bit}),
		.wdata ({tax_q, pos_q}),
		.re    (cmd.lookup),
		.raddr (slot_q),
		.rdata (dr_rdata)
	);

	// a word never written reads as all free
	assign live_word = wvalid_q[word_q] ? lm_rdata : '0;

	always_comb begin
		free_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!live_word[i]) begin
				free_bit = BIT_W'(i);
			end
		end
	end

	assign bit_sel  = is_insert ? free_bit : slot_q[BIT_W-1:0];
	assign bit_mask = WORD_BITS'(1) << bit_sel;
	assign cur_live = live_word[slot_q[BIT_W-1:0]];

	always_comb begin
		new_word   = live_word;
		lm_we      = 1'b0;
		dr_we      = 1'b0;
		count_d    = count_q;
		res_status = ST_OK;
		res_slot   = slot_q;
		res_live   = 1'b0;
		res_pos    = '0;
		res_tax    = '0;
		priority if (is_insert) begin
			if (tbl_full) begin
				res_status = ST_FULL;
				res_slot   = '0;
			end else begin
				new_word = live_word | bit_mask;
				lm_we    = cmd.eval;
				dr_we    = cmd.eval;
				count_d  = count_q + CNT_W'(1);
				res_slot = {word_q, free_bit};
			end
		end else if (is_remove) begin
			if (cur_live) begin
				new_word = live_word & ~bit_mask;
				lm_we    = cmd.eval;
				count_d  = count_q - CNT_W'(1);
			end else begin
				res_status = ST_NOT_LIVE;
			end
		end else begin
			// spare operation code is served as a query
			if (cur_live) begin
				res_live = 1'b1;
				res_pos  = dr_rdata[DATA_W-1:0];
				res_tax  = dr_rdata[2*DATA_W-1:DATA_W];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			wvalid_q    <= '0;
			word_full_q <= '0;
			m_tvalid_q  <= 1'b0;
		end else begin
			if (cmd.eval) begin
				count_q <= count_d;
			end
			if (lm_we) begin
				wvalid_q[word_q]    <= 1'b1;
				word_full_q[word_q] <= &new_word;
			end
			if (cmd.eval) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			status_q    <= res_status;
			slot_out_q  <= res_slot;
			live_out_q  <= res_live;
			pos_out_q   <= res_pos;
			tax_out_q   <= res_tax;
			count_out_q <= count_d;
		end
	end

	assign sts.out_free    = !m_tvalid_q || m_tready;
	assign m_tvalid        = m_tvalid_q;
	assign status          = status_q;
	assign assigned_slot   = slot_out_q;
	assign slot_live       = live_out_q;
	assign stored_position = pos_out_q;
	assign stored_taxon    = tax_out_q;
	assign live_count      = count_out_q;

`ifndef SYNTHESIS
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(SLOTS))
		else $error("live count above table size");

	a_full_words: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_full == (&word_full_q))
		else $error("full word flags disagree with live count");

	a_full_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(word_full_q & ~wvalid_q) == '0)
		else $error("word flagged full but never written");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval && is_insert && !tbl_full |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("insert did not raise live count");

	a_rm_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.eval && is_remove && cur_live |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("remove did not lower live count");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/lfsa_checker.sv =====
// lfsa_checker: watches both stream channels of the slot allocator, predicts each result
// and compares it field by field; depends on lfsa_pkg only
`default_nettype none
module lfsa_checker
	import lfsa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [79:0] s_tdata,  // slot_index, position, taxon, zero pad
	input  wire logic [1:0]  s_tuser,  // operation
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [87:0] m_tdata,  // assigned_slot, slot_live, stored_position,
	                                   // stored_taxon, live_count, zero pad
	input  wire logic [1:0]  m_tuser,  // status
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		status_t             status;
		logic [SLOT_W-1:0]   slot;
		logic                live;
		logic [DATA_W-1:0]   pos;
		logic [DATA_W-1:0]   tax;
		logic [CNT_W-1:0]    count;
	} slot_reply_t;

	bit                occupied [SLOTS];
	logic [DATA_W-1:0] pos_mem  [SLOTS];
	logic [DATA_W-1:0] tax_mem  [SLOTS];
	int                mark;
	int                live_total;
	slot_reply_t       replies_due[$];
	int                errors = 0;
	int                waiting = 0;

	assign fail_count = errors;
	assign pending    = waiting;

	task automatic report_mismatch(string what, logic [DATA_W-1:0] seen,
			logic [DATA_W-1:0] wanted);
		$display("%0t ns: result mismatch on %s: got %h, want %h", $time, what, seen, wanted);
		errors++;
	endtask

	// one request against the table copy; operation code 3 falls through as a query
	function automatic slot_reply_t serve_request(logic [1:0] op, logic [SLOT_W-1:0] idx,
			logic [DATA_W-1:0] pos, logic [DATA_W-1:0] tax);
		slot_reply_t res;
		int          pick;
		bit          hit;
		res = '0;
		res.status = ST_OK;
		res.slot = idx;
		hit = (idx < mark) && occupied[idx];
		if (op == OP_INSERT) begin
			pick = -1;
			for (int i = 0; i < mark; i++) begin
				if (!occupied[i]) begin
					pick = i;
					break;
				end
			end
			if (pick < 0 && mark >= SLOTS) begin
				res.status = ST_FULL;
				res.slot = '0;
			end else begin
				if (pick < 0) begin
					pick = mark;
					mark++;
				end
				occupied[pick] = 1'b1;
				pos_mem[pick] = pos;
				tax_mem[pick] = tax;
				live_total++;
				res.slot = pick[SLOT_W-1:0];
			end
		end else if (op == OP_REMOVE) begin
			if (!hit) begin
				res.status = ST_NOT_LIVE;
			end else begin
				occupied[idx] = 1'b0;
				live_total--;
			end
		end else if (hit) begin
			res.live = 1'b1;
			res.pos = pos_mem[idx];
			res.tax = tax_mem[idx];
		end
		res.count = live_total[CNT_W-1:0];
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		slot_reply_t got;
		slot_reply_t want;
		if (!arst_n) begin
			foreach (occupied[i]) occupied[i] = 1'b0;
			mark = 0;
			live_total = 0;
			replies_due.delete();
			waiting = 0;
		end else begin
			// results first: a request taken at this edge cannot be answered at it
			if (m_tvalid && m_tready) begin
				got.status = status_t'(m_tuser);
				got.slot   = m_tdata[9:0];
				got.live   = m_tdata[10];
				got.pos    = m_tdata[42:11];
				got.tax    = m_tdata[74:43];
				got.count  = m_tdata[85:75];
				if (replies_due.size() == 0) begin
					report_mismatch("unexpected result, assigned_slot",
						DATA_W'(got.slot), '0);
				end else begin
					want = replies_due.pop_front();
					if (got.status !== want.status)
						report_mismatch("status", DATA_W'(got.status),
							DATA_W'(want.status));
					if (got.slot !== want.slot)
						report_mismatch("assigned_slot", DATA_W'(got.slot),
							DATA_W'(want.slot));
					if (got.live !== want.live)
						report_mismatch("slot_live", DATA_W'(got.live),
							DATA_W'(want.live));
					if (got.pos !== want.pos)
						report_mismatch("stored_position", got.pos, want.pos);
					if (got.tax !== want.tax)
						report_mismatch("stored_taxon", got.tax, want.tax);
					if (got.count !== want.count)
						report_mismatch("live_count", DATA_W'(got.count),
							DATA_W'(want.count));
				end
			end
			if (s_tvalid && s_tready)
				replies_due = {replies_due, serve_request(s_tuser, s_tdata[9:0],
					s_tdata[41:10], s_tdata[73:42])};
			waiting = replies_due.size();
		end
	end

endmodule
`default_nettype wire

// ===== tb/sv/tb_lowest_free_slot_allocator_unit.sv =====
// tb_lowest_free_slot_allocator_unit: clock, reset and request stimulus for the slot allocator
// depends on lfsa_pkg, lowest_free_slot_allocator_unit and lfsa_checker
`default_nettype none
module tb_lowest_free_slot_allocator_unit
	import lfsa_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// spare operation code, decoded by the block as a query
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int PHASES = 4;
	localparam int PHASE_ITEMS = 120;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 12;

	localparam int IDLE_PCT  [PHASES] = '{0, 67, 0, 31};
	localparam int STALL_PCT [PHASES] = '{0, 0, 67, 31};
	localparam int INSERT_W  [PHASES] = '{50, 35, 50, 30};
	localparam int REMOVE_W  [PHASES] = '{25, 40, 20, 45};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic [79:0] s_tdata = '0;
	logic [1:0]  s_tuser = OP_QUERY;
	logic        m_tready = 1'b0;
	wire logic        s_tready;
	wire logic        m_tvalid;
	wire logic [87:0] m_tdata;
	wire logic [1:0]  m_tuser;
	int          failures;
	int          outstanding;

	int idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_served = 0;
	int hold_left = 0;
	int inserts_sent = 0;

	lowest_free_slot_allocator_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	lfsa_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.fail_count (failures),
		.pending    (outstanding)
	);

	always #10 clk = ~clk;

	// result side: random stalls, or a long hold-off when one is asked for
	always @(posedge clk) begin
		if (hold_asked != hold_served) begin
			hold_served = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	task automatic send_request(logic [1:0] op, logic [SLOT_W-1:0] slot,
			logic [DATA_W-1:0] pos, logic [DATA_W-1:0] tax);
		if ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {6'b0, tax, pos, slot};
		s_tuser  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// mostly slots that may be in use, now and then anywhere in the table
	task automatic random_request(int insert_w, int remove_w);
		logic [1:0] op;
		int         roll;
		int         span;
		roll = $urandom_range(0, 99);
		if (roll < insert_w)
			op = OP_INSERT;
		else if (roll < insert_w + remove_w)
			op = OP_REMOVE;
		else
			op = ($urandom_range(0, 7) == 0) ? OP_SPARE : OP_QUERY;
		if (op == OP_INSERT)
			inserts_sent++;
		span = (inserts_sent + 3 < SLOTS - 1) ? inserts_sent + 3 : SLOTS - 1;
		if ($urandom_range(0, 99) < 85)
			send_request(op, SLOT_W'($urandom_range(0, span)), $urandom, $urandom);
		else
			send_request(op, SLOT_W'($urandom_range(0, SLOTS - 1)), $urandom, $urandom);
	endtask

	// wait on the clock first so the count already holds the last transaction sent
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: everything beyond the mark, then first inserts with extreme field values
		send_request(OP_QUERY,  10'd0,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_REMOVE, 10'd0,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_REMOVE, 10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_QUERY,  10'd1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 10'd1023, 32'h0000_0000, 32'h0000_0000);
		send_request(OP_INSERT, 10'd0,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(OP_INSERT, 10'h2AA, 32'hAAAA_AAAA, 32'h5555_5555);
		send_request(OP_QUERY,  10'd0,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_QUERY,  10'd1,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_QUERY,  10'd2,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_SPARE,  10'd1,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_SPARE,  10'd700, 32'h0000_0000, 32'h0000_0000);
		// a hole below the mark is reused ahead of the mark
		send_request(OP_REMOVE, 10'd1,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_QUERY,  10'd1,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_REMOVE, 10'd1,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_INSERT, 10'h155, 32'h5555_5555, 32'hAAAA_AAAA);
		send_request(OP_QUERY,  10'd1,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_REMOVE, 10'd0,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_REMOVE, 10'd2,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_QUERY,  10'd5,   32'h0000_0000, 32'h0000_0000);
		send_request(OP_INSERT, 10'd0,   32'h1234_5678, 32'h8765_4321);
		send_request(OP_QUERY,  10'd0,   32'h0000_0000, 32'h0000_0000);
		drain();
		inserts_sent = 4;

		for (int p = 0; p < PHASES; p++) begin
			idle_pct = IDLE_PCT[p];
			stall_pct = STALL_PCT[p];
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// receiver holds off while requests keep coming, filling the block
				if (p == 0 && n == 40)
					hold_asked++;
				random_request(INSERT_W[p], REMOVE_W[p]);
			end
			drain();
		end

		// removes anywhere in the table, then a mixed tail
		idle_pct = 31;
		stall_pct = 31;
		repeat (20)
			send_request(OP_REMOVE, SLOT_W'($urandom_range(0, SLOTS - 1)), $urandom,
				$urandom);
		repeat (20)
			random_request(40, 30);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
`default_nettype wire
